// ===== src/nvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvrs_pkg
// Shared types and constants of the nearest-value request scheduler.
// ----------------------------------------------------------------------------
package nvrs_pkg;

  localparam int DEF_MAX_ENTRIES    = 16;
  localparam int DEF_MAX_REQUESTERS = 16;

  localparam int OWNER_W = 4;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int LAST_W  = POS_W + 1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REQ_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] CAPACITY_RESET  = 5'd4;
  localparam logic [CFG_W-1:0] REQ_COUNT_RESET = 5'd16;

  // Input kinds carried on tuser.
  localparam logic MODE_POST   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [POS_W-1:0]   position;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] capacity;
    logic             live_load;
    logic [CFG_W-1:0] live_value;
  } cfg_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    entry_t entry;
  } serve_t;

endpackage

// ===== src/nvrs_table.sv =====
// ----------------------------------------------------------------------------
// nvrs_table
// Pending request table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nvrs_table #(
  parameter int DEPTH = nvrs_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  nvrs_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output nvrs_pkg::entry_t          rdata
);
  import nvrs_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/nvrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvrs_ctrl
// Sequencer: inserts requests, counts finishing requesters down, scans the
// table for the nearest entry, emits it and closes the gap it leaves.
// ----------------------------------------------------------------------------
module nvrs_ctrl #(
  parameter int MAX_ENTRIES    = nvrs_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_REQUESTERS = nvrs_pkg::DEF_MAX_REQUESTERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  nvrs_pkg::entry_t                in_entry,
  input  nvrs_pkg::cfg_ctrl_t             cfg,
  input  logic                            out_free,
  output nvrs_pkg::serve_t                serve,
  output logic                            mem_we,
  output logic [$clog2(MAX_ENTRIES)-1:0]  mem_waddr,
  output nvrs_pkg::entry_t                mem_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0]  mem_raddr,
  input  nvrs_pkg::entry_t                mem_rdata
);
  import nvrs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int LIVE_W = $clog2(MAX_REQUESTERS + 1);
  localparam int MAX_CL = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
  localparam int CMP_W  = (MAX_CL > CFG_W) ? MAX_CL : CFG_W;
  localparam int DIST_W = POS_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [LAST_W-1:0] last_served_r, last_served_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  entry_t            best_ent_r, best_ent_nxt;

  logic [LIVE_W-1:0] live_load_val;
  logic [CMP_W-1:0]  cap_eff, thr, cnt_ext, cnt_m1_ext;
  logic              serve_now, more_after;
  logic signed [DIST_W:0] diff;
  logic [DIST_W-1:0] seek_dist;
  logic              take;

  // Saturated live count for a requester_count load.
  assign live_load_val = (32'(cfg.live_value) > MAX_REQUESTERS) ?
                         LIVE_W'(MAX_REQUESTERS) : LIVE_W'(cfg.live_value);

  // Serving threshold: min(live, clamped capacity).
  always_comb begin
    if (cfg.capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (32'(cfg.capacity) > MAX_ENTRIES) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(cfg.capacity);
    end
    thr = (CMP_W'(live_r) < cap_eff) ? CMP_W'(live_r) : cap_eff;
  end

  assign cnt_ext    = CMP_W'(count_r);
  assign cnt_m1_ext = CMP_W'(count_r - CNT_W'(1));
  assign serve_now  = (count_r != '0) && (cnt_ext >= thr);
  assign more_after = (cnt_m1_ext != '0) && (cnt_m1_ext >= thr);

  // Exact distance of the returned entry to the last served position.
  assign diff = $signed({2'b00, mem_rdata.position}) -
                $signed({last_served_r[LAST_W-1], last_served_r});
  assign seek_dist = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
  assign take = (idx_r == '0) || (seek_dist < best_d_r);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    live_nxt        = live_r;
    last_served_nxt = last_served_r;
    idx_nxt         = idx_r;
    best_idx_nxt    = best_idx_r;
    best_d_nxt      = best_d_r;
    best_ent_nxt    = best_ent_r;
    serve           = '0;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = mem_rdata;
    mem_raddr       = idx_r + IDX_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_POST) begin
            if (live_r != '0 && 32'(count_r) < MAX_ENTRIES) begin
              mem_we    = 1'b1;
              mem_waddr = count_r[IDX_W-1:0];
              mem_wdata = in_entry;
              count_nxt = count_r + CNT_W'(1);
              state_nxt = ST_CHECK;
            end
          end else if (live_r != '0) begin
            live_nxt  = live_r - LIVE_W'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        mem_raddr = '0;
        idx_nxt   = '0;
        state_nxt = serve_now ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_nxt = idx_r;
          best_d_nxt   = seek_dist;
          best_ent_nxt = mem_rdata;
        end
        if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        mem_raddr = best_idx_r + IDX_W'(1);
        if (out_free) begin
          serve.valid     = 1'b1;
          serve.last      = !more_after;
          serve.entry     = best_ent_r;
          last_served_nxt = {1'b0, best_ent_r.position};
          if (CNT_W'(best_idx_r) + CNT_W'(1) < count_r) begin
            idx_nxt   = best_idx_r;
            state_nxt = ST_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_SHIFT: begin
        // Entry idx_r+1 has arrived; move it down one place.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx_r + IDX_W'(2);
        if (CNT_W'(idx_r) + CNT_W'(2) == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_CHECK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg.live_load) begin
      live_nxt = live_load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      live_r        <= (32'(REQ_COUNT_RESET) > MAX_REQUESTERS) ?
                       LIVE_W'(MAX_REQUESTERS) : LIVE_W'(REQ_COUNT_RESET);
      last_served_r <= '1;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      live_r        <= live_nxt;
      last_served_r <= last_served_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    best_ent_r <= best_ent_nxt;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ENTRIES)
    else $error("pending count above table depth");

  a_live_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_r) <= MAX_REQUESTERS)
    else $error("live count above requester limit");

  a_serve_free : assert property (@(posedge clk) disable iff (!rst_n)
    serve.valid |-> out_free)
    else $error("serve issued while output register occupied");

  a_shift_in_table : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (CNT_W'(mem_waddr) + CNT_W'(1) < count_r))
    else $error("compaction write outside the pending table");

  a_serve_leaves_check : assert property (@(posedge clk) disable iff (!rst_n)
    (serve.valid && (state_r == ST_EMIT) &&
     (CNT_W'(best_idx_r) + CNT_W'(1) == count_r)) |=> (state_r == ST_CHECK))
    else $error("serve of the newest entry did not return to the check");

endmodule

// ===== src/nearest_value_request_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// nearest_value_request_scheduler_top
// Shortest-seek-first request table with streaming ports.
// ----------------------------------------------------------------------------
// Each input transaction either posts a request (owner id and a position from
// 0 to 1023) or reports that a requester has finished. After each accepted
// transaction the block serves entries for as long as the table holds at
// least min(live requesters, capacity) entries; each serve picks the entry
// nearest the last served position (which starts at -1), the oldest entry on
// a tie, and emits it as one output transaction, the last one for that input
// carrying tlast. Once the live count reaches zero the table drains. All
// requests sit in one single-port-read, single-port-write table with
// registered read data, so the work is sequential: every serve runs a check
// step, a scan step per pending entry, an emit step and a compaction step
// for each entry newer than the winner. Input is taken only while no serve
// is in progress; the output register lets the next transaction in while
// the final result still waits to be taken, and a stalled output stalls the
// scheduler in its emit step. Configuration writes are always accepted and
// are meant to be made while the block is idle; writing requester_count
// reloads the live count.
// ----------------------------------------------------------------------------
module nearest_value_request_scheduler_top #(
  parameter int MAX_ENTRIES    = nvrs_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_REQUESTERS = nvrs_pkg::DEF_MAX_REQUESTERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, from bit 0: requester [3:0], position [13:4], zero padding [15:14].
  input  logic [nvrs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: mode (0 post, 1 finish).
  input  logic                               in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, from bit 0: served_requester [3:0], served_position [13:4],
  // zero padding [15:14].
  output logic [nvrs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tlast: last_of_run.
  output logic                               out_tlast,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nvrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nvrs_pkg::CFG_W-1:0]         cfg_data
);
  import nvrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  logic [CFG_W-1:0] capacity_r;
  logic             cfg_write;
  cfg_ctrl_t        cfg;
  entry_t           in_entry;
  serve_t           serve;
  logic             out_free;

  logic             out_valid_r;
  entry_t           out_entry_r;
  logic             out_last_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // Configuration: capacity is held here, requester_count is a live-count load.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_write && cfg_index == CFG_IDX_CAPACITY) begin
      capacity_r <= cfg_data;
    end
  end

  assign cfg.capacity   = capacity_r;
  assign cfg.live_load  = cfg_write && (cfg_index == CFG_IDX_REQ_COUNT);
  assign cfg.live_value = cfg_data;

  assign in_entry.owner    = in_tdata[OWNER_W-1:0];
  assign in_entry.position = in_tdata[OWNER_W+POS_W-1:OWNER_W];

  nvrs_table #(
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nvrs_ctrl #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_entry  (in_entry),
    .cfg       (cfg),
    .out_free  (out_free),
    .serve     (serve),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: it may be reloaded in the cycle its transaction completes.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (serve.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (serve.valid) begin
      out_entry_r <= serve.entry;
      out_last_r  <= serve.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OWNER_W - POS_W)'(0),
                       out_entry_r.position, out_entry_r.owner};
  assign out_tlast  = out_last_r;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the nearest-value request scheduler.
// ----------------------------------------------------------------------------
// Posts and finish transactions go into the block through the input stream.
// A scoreboard keeps its own copy of the request table and, for every
// accepted transaction, works out which entries must be served and in which
// order. Each result taken from the output stream is compared field by field
// with the oldest outstanding serve. A short directed part covers the field
// extremes and the special cases. It is followed by random request sessions
// under four idling modes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nvrs_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 250;
  localparam int HOLD_CYCLES   = 400;

  // Indexes beyond the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: a model of the request table and the queue of due serves.
  // --------------------------------------------------------------------------
  class seek_scoreboard;
    typedef struct {
      logic [OWNER_W-1:0] owner;
      logic [POS_W-1:0]   position;
      logic               last;
    } serve_rec_t;

    logic [POS_W-1:0]   table_pos[DEF_MAX_ENTRIES];
    logic [OWNER_W-1:0] table_owner[DEF_MAX_ENTRIES];
    int unsigned        held;
    int                 last_pos;
    int unsigned        live_count;
    int unsigned        capacity;
    serve_rec_t         due_serves[$];
    int                 errors;
    int                 results_seen;
    int                 taken_items;
    int                 ignored_items;
    int                 reg_writes;

    function new();
      held          = 0;
      last_pos      = -1;
      capacity      = CAPACITY_RESET;
      live_count    = load_live(REQ_COUNT_RESET);
      errors        = 0;
      results_seen  = 0;
      taken_items   = 0;
      ignored_items = 0;
      reg_writes    = 0;
    endfunction

    function int unsigned load_live(logic [CFG_W-1:0] val);
      return (val > DEF_MAX_REQUESTERS) ? DEF_MAX_REQUESTERS : val;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      reg_writes++;
      if (idx == CFG_IDX_CAPACITY) begin
        capacity = val;
      end else if (idx == CFG_IDX_REQ_COUNT) begin
        live_count = load_live(val);
      end
    endfunction

    // Serves nearest entries while the table reaches the threshold.
    function void serve_nearest();
      serve_rec_t  batch[$];
      serve_rec_t  rec;
      int unsigned cap;
      int unsigned thr;
      int unsigned best;
      int          best_d;
      int          d;
      cap = (capacity == 0) ? 1 : capacity;
      if (cap > DEF_MAX_ENTRIES) cap = DEF_MAX_ENTRIES;
      thr = (live_count < cap) ? live_count : cap;
      while (held > 0 && held >= thr) begin
        best   = 0;
        best_d = int'(table_pos[0]) - last_pos;
        if (best_d < 0) best_d = -best_d;
        for (int unsigned i = 1; i < held; i++) begin
          d = int'(table_pos[i]) - last_pos;
          if (d < 0) d = -d;
          // Strictly nearer only, so the oldest entry wins a tie.
          if (d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        rec.owner    = table_owner[best];
        rec.position = table_pos[best];
        rec.last     = 1'b0;
        batch = {batch, rec};
        last_pos = int'(table_pos[best]);
        for (int unsigned i = best; i + 1 < held; i++) begin
          table_pos[i]   = table_pos[i + 1];
          table_owner[i] = table_owner[i + 1];
        end
        held--;
      end
      foreach (batch[i]) begin
        rec      = batch[i];
        rec.last = (i == batch.size() - 1);
        due_serves = {due_serves, rec};
      end
    endfunction

    function void note_input(logic mode, logic [OWNER_W-1:0] owner,
                             logic [POS_W-1:0] position);
      if (mode == MODE_POST) begin
        if (live_count == 0 || held >= DEF_MAX_ENTRIES) begin
          ignored_items++;
          return;
        end
        table_pos[held]   = position;
        table_owner[held] = owner;
        held++;
      end else begin
        if (live_count == 0) begin
          ignored_items++;
          return;
        end
        live_count--;
      end
      taken_items++;
      serve_nearest();
    endfunction

    function void check_result(logic [OWNER_W-1:0] owner, logic [POS_W-1:0] position,
                               logic last);
      serve_rec_t exp_rec;
      results_seen++;
      if (due_serves.size() == 0) begin
        $error("unexpected result: served_requester %0d, served_position %0d",
               owner, position);
        errors++;
        return;
      end
      exp_rec = due_serves.pop_front();
      if (owner !== exp_rec.owner) begin
        $error("served_requester: expected %0d, actual %0d", exp_rec.owner, owner);
        errors++;
      end
      if (position !== exp_rec.position) begin
        $error("served_position: expected %0d, actual %0d", exp_rec.position, position);
        errors++;
      end
      if (last !== exp_rec.last) begin
        $error("last_of_run: expected %0d, actual %0d", exp_rec.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  seek_scoreboard sb;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  bit pressure_done = 1'b0;

  nearest_value_request_scheduler_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Guard against a hung block: the run ends as failed if it overruns.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. A hold-off request from the stimulus is loaded here and counted
  // down cycle by cycle; otherwise tready is dropped at the current stall rate.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every result transaction is checked at the edge on which it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[OWNER_W-1:0], out_tdata[OWNER_W +: POS_W], out_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. The send task is entered just after a rising edge and leaves at
  // the edge on which its transaction was taken, so a following transaction
  // may keep tvalid high without a gap.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic mode, input logic [OWNER_W-1:0] owner,
                           input logic [POS_W-1:0] position);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, position, owner};
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, owner, position);
  endtask

  // Registers may only change while the block is idle: input closed, every
  // due serve delivered, and time for a serve-free post to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.due_serves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] random_position();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return POS_W'($urandom_range(1000, 1023));
    // Clustered values make equal distances, and so ties, common.
    if (pick < 28) return POS_W'($urandom_range(0, 3) * 333);
    return POS_W'($urandom_range(0, 999));
  endfunction

  // One session: a fresh setting, posts mixed with finishes until every
  // requester has finished, then a little noise that the block must ignore.
  // Now and then a session is cut short, leaving entries for the next one.
  task automatic run_session(input bit pressure);
    logic [CFG_W-1:0] cap;
    logic [CFG_W-1:0] count;
    int unsigned      pick;
    int               steps;
    wait_idle();
    pick = $urandom_range(9);
    case (pick)
      0:       cap = '0;
      1:       cap = CFG_W'($urandom_range(17, 31));
      2:       cap = CFG_W'(DEF_MAX_ENTRIES);
      3:       cap = 5'd1;
      default: cap = CFG_W'($urandom_range(1, 16));
    endcase
    pick = $urandom_range(11);
    case (pick)
      0:       count = '0;
      1:       count = CFG_W'($urandom_range(17, 31));
      default: count = CFG_W'($urandom_range(1, 16));
    endcase
    if (pressure) begin
      cap   = 5'd2;
      count = CFG_W'(DEF_MAX_REQUESTERS);
    end
    cfg_write(CFG_IDX_CAPACITY, cap);
    cfg_write(CFG_IDX_REQ_COUNT, count);
    if (pressure) hold_request = HOLD_CYCLES;
    steps = 0;
    while (sb.live_count > 0) begin
      if (steps >= 30 || $urandom_range(99) < 20) begin
        send_item(MODE_FINISH, OWNER_W'($urandom), random_position());
      end else begin
        send_item(MODE_POST, OWNER_W'($urandom), random_position());
      end
      steps++;
      if (!pressure && steps > 3 && $urandom_range(99) < 3) break;
    end
    if (sb.live_count == 0 && $urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 2)) begin
        send_item(1'($urandom), OWNER_W'($urandom), random_position());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int random_start;
    int sessions;
    sb = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= MODE_POST;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_IDX_CAPACITY;
    cfg_data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset setting (capacity four, sixteen
    // live requesters). The fourth post reaches the threshold and serves the
    // entry nearest -1; the next serve is a tie between two entries at 500,
    // which the older one must win.
    send_item(MODE_POST, 4'd0, 10'd0);
    send_item(MODE_POST, 4'd15, 10'd999);
    send_item(MODE_POST, 4'd5, 10'd1023);
    send_item(MODE_POST, 4'd10, 10'd500);
    send_item(MODE_POST, 4'd3, 10'd500);
    // The requester field of a finish carries no meaning.
    send_item(MODE_FINISH, 4'd15, 10'd1023);

    // A zero requester count: posts and finishes alike are ignored.
    wait_idle();
    cfg_write(CFG_IDX_REQ_COUNT, 5'd0);
    send_item(MODE_POST, 4'd7, 10'd1);
    send_item(MODE_FINISH, 4'd0, 10'd0);

    // One live requester finishing drains the remaining entries, far ones too.
    wait_idle();
    cfg_write(CFG_IDX_REQ_COUNT, 5'd1);
    send_item(MODE_FINISH, 4'd9, 10'd0);

    // Writes to unused indexes, then a zero capacity (treated as one) and an
    // oversized requester count (saturating at the maximum).
    wait_idle();
    cfg_write(CFG_IDX_SPARE_A, 5'h1f);
    cfg_write(CFG_IDX_SPARE_B, 5'h1f);
    cfg_write(CFG_IDX_CAPACITY, 5'd0);
    cfg_write(CFG_IDX_REQ_COUNT, 5'd31);
    send_item(MODE_POST, 4'd12, 10'd300);
    send_item(MODE_POST, 4'd1, 10'd301);

    // An oversized capacity lets ten entries collect in the table, then a lowered
    // capacity makes a single post serve ten entries in one run.
    wait_idle();
    cfg_write(CFG_IDX_CAPACITY, 5'd31);
    for (int i = 0; i < 10; i++) begin
      send_item(MODE_POST, OWNER_W'(i + 2), POS_W'(i * 97 + 11));
    end
    wait_idle();
    cfg_write(CFG_IDX_CAPACITY, 5'd2);
    send_item(MODE_POST, 4'd14, 10'd640);
    wait_idle();
    cfg_write(CFG_IDX_REQ_COUNT, 5'd1);
    send_item(MODE_FINISH, 4'd0, 10'd0);

    // Random sessions, the idling mode following the progress of the run.
    random_start = sb.taken_items;
    sessions     = 0;
    while (sb.taken_items - random_start < RANDOM_ITEMS) begin
      case ((sb.taken_items - random_start) * 4 / RANDOM_ITEMS)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 45;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 45;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct     = 29;
        end
      endcase
      // Once, early on, the receiver holds off while the sender keeps going.
      if (!pressure_done && sessions == 2) begin
        run_session(1'b1);
        pressure_done = 1'b1;
      end else begin
        run_session(1'b0);
      end
      sessions++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input transactions (%0d of them ignored), %0d results",
             sb.taken_items + sb.ignored_items, sb.ignored_items, sb.results_seen);
    $display("over %0d register writes, four idling modes and one long receiver hold-off.",
             sb.reg_writes);
    if (sb.errors == 0 && sb.due_serves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== nearest_value_request_scheduler_top.f =====
src/nvrs_pkg.sv
src/nvrs_table.sv
src/nvrs_ctrl.sv
src/nearest_value_request_scheduler_top.sv
test/tb_top.sv
